[design/laplace_gauss_seidel_solver_top_defines.svh]
// Assertion macros for the Laplace Gauss-Seidel solver.
// Included by the top level; needs no package.
`ifndef LAPLACE_GAUSS_SEIDEL_SOLVER_TOP_DEFINES_SVH
`define LAPLACE_GAUSS_SEIDEL_SOLVER_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
// Property that must hold at every clock edge outside reset.
`define LGS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Consequence that must hold in the cycle after the antecedent.
`define LGS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define LGS_ASSERT(lbl, clk, rst, prop, msg)
`define LGS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

[design/lgs_pkg.sv]
// Shared widths, codes, types and the microcode table of the Laplace solver.
// No dependencies; compiled first.
`default_nettype none

package lgs_pkg;

  // Field and register widths.
  localparam int GRID_MAX_DEF = 16;
  localparam int VALUE_W      = 32;
  localparam int COORD_W      = 4;
  localparam int MODE_W       = 2;
  localparam int SIZE_W       = 5;
  localparam int TOL_W        = 31;
  localparam int SWEEP_W      = 16;
  localparam int CFG_DATA_W   = 31;
  localparam int CFG_INDEX_W  = 2;

  // Request modes.
  localparam logic [MODE_W-1:0] MODE_WRITE = MODE_W'(0);
  localparam logic [MODE_W-1:0] MODE_READ  = MODE_W'(1);
  localparam logic [MODE_W-1:0] MODE_SOLVE = MODE_W'(2);

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_GRID_SIZE  = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_TOLERANCE  = CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_SWEEPS = CFG_INDEX_W'(2);

  // Configuration reset values.
  localparam logic [SIZE_W-1:0]  GRID_SIZE_RST  = SIZE_W'(10);
  localparam logic [TOL_W-1:0]   TOLERANCE_RST  = TOL_W'(655);
  localparam logic [SWEEP_W-1:0] MAX_SWEEPS_RST = SWEEP_W'(1000);

  // Top-level control state.
  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  // Microcode fields.
  localparam int UPC_W = 4;
  typedef logic [UPC_W-1:0] upc_t;

  typedef enum logic [2:0] {
    AS_NONE,
    AS_UP,
    AS_DOWN,
    AS_LEFT,
    AS_RIGHT,
    AS_CENTER
  } addr_sel_t;

  typedef enum logic [1:0] {
    AC_HOLD,
    AC_LOAD,
    AC_ADD
  } acc_op_t;

  typedef enum logic [2:0] {
    BR_NEXT,
    BR_NO_INTERIOR,
    BR_MORE_CELLS,
    BR_AGAIN,
    BR_FINISH
  } branch_t;

  typedef struct packed {
    addr_sel_t asel;
    acc_op_t   acc;
    logic      sweep_init;
    logic      cell_write;
    logic      track;
    branch_t   br;
    upc_t      target;
  } ucode_t;

  // Program steps.
  localparam upc_t UPC_SWEEP  = UPC_W'(0);
  localparam upc_t UPC_CELL   = UPC_W'(1);
  localparam upc_t UPC_DOWN   = UPC_W'(2);
  localparam upc_t UPC_LEFT   = UPC_W'(3);
  localparam upc_t UPC_RIGHT  = UPC_W'(4);
  localparam upc_t UPC_CENTER = UPC_W'(5);
  localparam upc_t UPC_WRITE  = UPC_W'(6);
  localparam upc_t UPC_TRACK  = UPC_W'(7);
  localparam upc_t UPC_CHECK  = UPC_W'(8);
  localparam upc_t UPC_DONE   = UPC_W'(9);

  // The solve program. Each step issues at most one grid read; its read data
  // is taken up by the step that follows.
  function automatic ucode_t ucode_rom(input upc_t pc);
    ucode_t w;
    w = '{asel: AS_NONE, acc: AC_HOLD, sweep_init: 1'b0, cell_write: 1'b0,
          track: 1'b0, br: BR_NEXT, target: UPC_SWEEP};
    case (pc)
      UPC_SWEEP: begin
        w.sweep_init = 1'b1;
        w.br         = BR_NO_INTERIOR;
        w.target     = UPC_CHECK;
      end
      UPC_CELL: begin
        w.asel = AS_UP;
      end
      UPC_DOWN: begin
        w.asel = AS_DOWN;
        w.acc  = AC_LOAD;
      end
      UPC_LEFT: begin
        w.asel = AS_LEFT;
        w.acc  = AC_ADD;
      end
      UPC_RIGHT: begin
        w.asel = AS_RIGHT;
        w.acc  = AC_ADD;
      end
      UPC_CENTER: begin
        w.asel = AS_CENTER;
        w.acc  = AC_ADD;
      end
      UPC_WRITE: begin
        w.cell_write = 1'b1;
      end
      UPC_TRACK: begin
        w.track  = 1'b1;
        w.br     = BR_MORE_CELLS;
        w.target = UPC_CELL;
      end
      UPC_CHECK: begin
        w.br     = BR_AGAIN;
        w.target = UPC_SWEEP;
      end
      UPC_DONE: begin
        w.br = BR_FINISH;
      end
      default: begin
        w.br = BR_FINISH;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

[design/lgs_if.sv]
// Request and response channel interfaces of the Laplace solver.
// Depends on lgs_pkg for the field widths.
`default_nettype none

// Request channel: one cell write, cell read or solve per request.
interface lgs_req_if import lgs_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [MODE_W-1:0]         mode;
  logic [COORD_W-1:0]        row;
  logic [COORD_W-1:0]        col;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output mode, output row, output col, output value,
                  input ready);
  modport sink (input valid, input mode, input row, input col, input value,
                output ready);
endinterface

// Response channel: one result per request.
interface lgs_rsp_if import lgs_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] cell_value;
  logic [SWEEP_W-1:0]        sweep_count;
  logic                      converged;

  modport source (output valid, output cell_value, output sweep_count, output converged,
                  input ready);
  modport sink (input valid, input cell_value, input sweep_count, input converged,
                output ready);
endinterface

`default_nettype wire

[design/laplace_gauss_seidel_solver_top.sv]
// Laplace Gauss-Seidel solver: grid store, microcoded sweep sequencer, result register.
// Depends on lgs_pkg, lgs_if and laplace_gauss_seidel_solver_top_defines.svh.
//
//   channel  direction  handshake      payload
//   req      in         valid/ready    mode, row, col, value
//   rsp      out        valid/ready    cell_value, sweep_count, converged
//   cfg      in         cfg_en         cfg_index, cfg_data
//
// Cell writes and reads are taken one per cycle while the response does not stall;
// a read result leaves through the pending stage and then a one-entry result register.
// A solve holds off requests until it finishes; with a grid size below three there
// is no interior and no cell is swept. The single grid read port serves five reads
// per cell. A finished solve also waits while the result register is still occupied.
// Synchronous reset clears control and configuration; the grid is not cleared.
// A stalled response stops new requests once the result register and the
// pending read stage are both full.
`default_nettype none
`include "laplace_gauss_seidel_solver_top_defines.svh"

module laplace_gauss_seidel_solver_top import lgs_pkg::*; #(
  parameter int GRID_MAX = GRID_MAX_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  lgs_req_if.sink                req,
  lgs_rsp_if.source              rsp
);

  localparam int IDX_W     = $clog2(GRID_MAX);
  localparam int CNT_W     = (IDX_W + 1 > SIZE_W) ? IDX_W + 1 : SIZE_W;
  localparam int CMP_W     = (IDX_W + 1 > COORD_W) ? IDX_W + 1 : COORD_W;
  localparam int ADDR_W    = 2 * IDX_W;
  localparam int MEM_DEPTH = 1 << ADDR_W;
  localparam int ACC_W     = VALUE_W + 2;
  localparam int DIFF_W    = VALUE_W + 1;

  // Configuration registers.
  logic [SIZE_W-1:0]  grid_size;
  logic [TOL_W-1:0]   tolerance;
  logic [SWEEP_W-1:0] max_sweeps;

  // Control state.
  state_t     state, state_next;
  upc_t       pc, pc_next;
  ucode_t     uc;

  // Sweep datapath.
  logic [CNT_W-1:0]         i, j;
  logic signed [ACC_W-1:0]  acc;
  logic signed [DIFF_W-1:0] diff;
  logic [VALUE_W-1:0]       largest;
  logic [SWEEP_W-1:0]       sweeps;

  // Grid store.
  logic [VALUE_W-1:0] mem [MEM_DEPTH];
  logic [VALUE_W-1:0] rdata;
  logic               mem_re, mem_we;
  logic [ADDR_W-1:0]  mem_raddr, mem_waddr;
  logic [VALUE_W-1:0] mem_wdata;

  // Pending read/write stage and result register.
  logic               p_valid;
  logic [MODE_W-1:0]  p_mode;
  logic               p_inside;
  logic [VALUE_W-1:0] p_value;
  logic               out_valid;
  logic [VALUE_W-1:0] out_cell_value;
  logic [SWEEP_W-1:0] out_sweep_count;
  logic               out_converged;

  logic               out_free, p_move, accept, in_store, run_done;
  logic [ADDR_W-1:0]  io_addr, seq_addr, center_addr;
  logic [CNT_W-1:0]   n_eff, last_idx, row_sel, col_sel;
  logic               no_interior, more_cells, again;
  logic [SWEEP_W-1:0] limit;
  logic signed [VALUE_W-1:0] nv;
  logic signed [DIFF_W-1:0]  diff_next;
  logic [DIFF_W-1:0]         mag;
  logic [VALUE_W-1:0]        mag_w;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size  <= GRID_SIZE_RST;
      tolerance  <= TOLERANCE_RST;
      max_sweeps <= MAX_SWEEPS_RST;
    end else if (cfg_en) begin
      case (cfg_index)
        REG_GRID_SIZE:  grid_size  <= cfg_data[SIZE_W-1:0];
        REG_TOLERANCE:  tolerance  <= cfg_data[TOL_W-1:0];
        REG_MAX_SWEEPS: max_sweeps <= cfg_data[SWEEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective grid size, last interior index and sweep limit.
  assign n_eff = (CNT_W'(grid_size) > CNT_W'(GRID_MAX)) ? CNT_W'(GRID_MAX)
                                                         : CNT_W'(grid_size);
  assign last_idx    = n_eff - CNT_W'(2);
  assign no_interior = n_eff < CNT_W'(3);
  assign limit       = (max_sweeps == '0) ? SWEEP_W'(1) : max_sweeps;
  assign more_cells  = !((i == last_idx) && (j == last_idx));
  assign again       = ({1'b0, tolerance} < largest) && (sweeps < limit);

  // Handshake.
  assign out_free  = !out_valid || rsp.ready;
  assign p_move    = p_valid && out_free;
  assign req.ready = (state == ST_IDLE) && (!p_valid || out_free);
  assign accept    = req.valid && req.ready;
  assign uc        = ucode_rom(pc);
  assign run_done  = (state == ST_RUN) && (uc.br == BR_FINISH) && out_free;

  // Request cell address; rows and columns past the store are ignored.
  assign in_store = (CMP_W'(req.row) < CMP_W'(GRID_MAX)) &&
                    (CMP_W'(req.col) < CMP_W'(GRID_MAX));
  assign io_addr  = {IDX_W'(req.row), IDX_W'(req.col)};

  // Neighbor selection for the sequencer's read.
  always_comb begin
    row_sel = i;
    col_sel = j;
    case (uc.asel)
      AS_UP:    row_sel = i - CNT_W'(1);
      AS_DOWN:  row_sel = i + CNT_W'(1);
      AS_LEFT:  col_sel = j - CNT_W'(1);
      AS_RIGHT: col_sel = j + CNT_W'(1);
      default: ;
    endcase
  end
  assign seq_addr    = {row_sel[IDX_W-1:0], col_sel[IDX_W-1:0]};
  assign center_addr = {i[IDX_W-1:0], j[IDX_W-1:0]};

  // Quarter-sum and change of the current cell.
  assign nv        = VALUE_W'(acc >>> 2);
  assign diff_next = DIFF_W'($signed(rdata)) - DIFF_W'(nv);
  assign mag       = diff[DIFF_W-1] ? -diff : diff;
  assign mag_w     = mag[VALUE_W-1:0];

  // Grid port owner: the sequencer while solving, requests otherwise.
  always_comb begin
    if (state == ST_RUN) begin
      mem_re    = uc.asel != AS_NONE;
      mem_raddr = seq_addr;
      mem_we    = uc.cell_write;
      mem_waddr = center_addr;
      mem_wdata = nv;
    end else begin
      mem_re    = accept && (req.mode == MODE_READ) && in_store;
      mem_raddr = io_addr;
      mem_we    = accept && (req.mode == MODE_WRITE) && in_store;
      mem_waddr = io_addr;
      mem_wdata = req.value;
    end
  end

  // Grid store with registered read data.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  // State and step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pc    <= UPC_SWEEP;
    end else begin
      state <= state_next;
      pc    <= pc_next;
    end
  end

  // Sequencer branches.
  always_comb begin
    state_next = state;
    pc_next    = pc;
    case (state)
      ST_IDLE: begin
        if (accept && (req.mode == MODE_SOLVE)) begin
          state_next = ST_RUN;
          pc_next    = UPC_SWEEP;
        end
      end
      ST_RUN: begin
        case (uc.br)
          BR_NEXT:        pc_next = pc + UPC_W'(1);
          BR_NO_INTERIOR: pc_next = no_interior ? uc.target : pc + UPC_W'(1);
          BR_MORE_CELLS:  pc_next = more_cells ? uc.target : pc + UPC_W'(1);
          BR_AGAIN:       pc_next = again ? uc.target : pc + UPC_W'(1);
          BR_FINISH: begin
            if (out_free) begin
              state_next = ST_IDLE;
            end
          end
          default: state_next = ST_IDLE;
        endcase
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sweep datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      sweeps  <= '0;
      largest <= '0;
    end else if (state == ST_IDLE) begin
      if (accept && (req.mode == MODE_SOLVE)) begin
        sweeps <= '0;
      end
    end else begin
      if (uc.sweep_init) begin
        sweeps  <= sweeps + SWEEP_W'(1);
        largest <= '0;
        i       <= CNT_W'(1);
        j       <= CNT_W'(1);
      end
      case (uc.acc)
        AC_LOAD: acc <= ACC_W'($signed(rdata));
        AC_ADD:  acc <= acc + ACC_W'($signed(rdata));
        default: ;
      endcase
      if (uc.cell_write) begin
        diff <= diff_next;
      end
      if (uc.track) begin
        if (mag_w > largest) begin
          largest <= mag_w;
        end
        if (j == last_idx) begin
          j <= CNT_W'(1);
          i <= i + CNT_W'(1);
        end else begin
          j <= j + CNT_W'(1);
        end
      end
    end
  end

  // Pending stage for reads, writes and the unused mode.
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (accept && (req.mode != MODE_SOLVE)) begin
      p_valid  <= 1'b1;
      p_mode   <= req.mode;
      p_inside <= in_store;
      p_value  <= req.value;
    end else if (p_move) begin
      p_valid <= 1'b0;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (run_done) begin
      out_valid       <= 1'b1;
      out_cell_value  <= '0;
      out_sweep_count <= sweeps;
      out_converged   <= largest <= {1'b0, tolerance};
    end else if (p_move) begin
      out_valid       <= 1'b1;
      out_sweep_count <= '0;
      out_converged   <= 1'b0;
      case (p_mode)
        MODE_WRITE: out_cell_value <= p_value;
        MODE_READ:  out_cell_value <= p_inside ? rdata : '0;
        default:    out_cell_value <= '0;
      endcase
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.cell_value  = out_cell_value;
  assign rsp.sweep_count = out_sweep_count;
  assign rsp.converged   = out_converged;

  // Sequencer stays inside its program while solving.
  `LGS_ASSERT(a_pc_range, clk, rst, (state == ST_RUN) |-> (pc <= UPC_DONE), "step counter left the program")
  // No solve runs past its sweep limit.
  `LGS_ASSERT(a_sweeps_bounded, clk, rst, (state == ST_RUN) |-> (sweeps <= limit), "sweep limit exceeded")
  // The pending stage is empty whenever the sequencer owns the grid.
  `LGS_ASSERT(a_no_pending_in_run, clk, rst, (state == ST_RUN) |-> !p_valid, "pending request during solve")
  // Relaxation writes land on interior cells only.
  `LGS_ASSERT(a_interior_write, clk, rst, (state == ST_RUN && uc.cell_write) |-> (i >= CNT_W'(1) && i <= last_idx && j >= CNT_W'(1) && j <= last_idx), "write outside interior")
  // A finished solve shows a result with zero cell value next cycle.
  `LGS_ASSERT_NEXT(a_solve_result, clk, rst, run_done, out_valid && out_cell_value == '0, "solve result missing")

endmodule

`default_nettype wire
